[hw/rtl/scl_pkg.sv]
// Shared types and constants of the sampled completion latency monitor.
package scl_pkg;

   localparam int STAT_W       = 32;
   localparam int INTERVAL_W   = 8;
   localparam int TIMESTAMP_W  = 48;
   localparam int COMMAND_W    = 2;
   localparam int TAG_W        = 2;
   localparam int BUSY_OUT_W   = 3;
   localparam int DIVISOR_W    = STAT_W + 1;
   localparam int DIV_STEPS    = STAT_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd8;
   localparam logic [STAT_W-1:0]     STAT_MAX       = '1;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_REJECT   = 2'd0,
      CMD_SEND     = 2'd1,
      CMD_COMPLETE = 2'd2,
      CMD_UNKNOWN  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MOD_WAIT,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [COMMAND_W-1:0]   command;
      logic                   send_ok;
      logic [TAG_W-1:0]       slot_tag;
      logic [TIMESTAMP_W-1:0] timestamp;
   } req_payload_type;

   typedef struct packed {
      logic                  sample_taken;
      logic [TAG_W-1:0]      claimed_slot;
      logic                  latency_updated;
      logic [STAT_W-1:0]     last_latency;
      logic [STAT_W-1:0]     max_latency;
      logic [STAT_W-1:0]     mean_latency;
      logic [STAT_W-1:0]     attempt_count;
      logic [STAT_W-1:0]     submitted_count;
      logic [STAT_W-1:0]     completed_count;
      logic [BUSY_OUT_W-1:0] pending_slots;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic bump_attempts;
      logic start_mod;
      logic try_claim;
      logic latch_latency;
      logic start_mean;
      logic commit;
      logic load_result;
   } ctrl_cmd_type;

   typedef struct packed {
      command_type command;
      logic        interval_zero;
      logic        hit;
      logic        first_completion;
      logic        div_done;
      logic        out_free;
   } ctrl_status_type;

endpackage

[hw/rtl/scl_req_if.sv]
// Request channel interface carrying one monitor transaction.
interface scl_req_if;
   logic                      valid;
   logic                      ready;
   scl_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/scl_rsp_if.sv]
// Response channel interface carrying one monitor result transaction.
interface scl_rsp_if;
   logic                      valid;
   logic                      ready;
   scl_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/scl_divider.sv]
// Restoring serial divider, one quotient bit per cycle, shared by modulo and mean.
module scl_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [scl_pkg::STAT_W-1:0]         dividend,
   input  logic [scl_pkg::DIVISOR_W-1:0]      divisor,
   output logic                               done,
   output logic [scl_pkg::STAT_W-1:0]         quotient,
   output logic [scl_pkg::DIVISOR_W-1:0]      remainder
);

   logic [scl_pkg::STAT_W-1:0]    quo_ff, quo_in;
   logic [scl_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [scl_pkg::DIVISOR_W-1:0] div_ff, div_in;
   logic [scl_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          running_ff, running_in;
   logic                          done_ff, done_in;
   logic [scl_pkg::DIVISOR_W:0]   shifted;
   logic [scl_pkg::DIVISOR_W+1:0] trial;
   logic                          take;

   always_comb begin
      shifted = {rem_ff, quo_ff[scl_pkg::STAT_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      take    = ~trial[scl_pkg::DIVISOR_W+1];

      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         div_in     = divisor;
         count_in   = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         quo_in   = {quo_ff[scl_pkg::STAT_W-2:0], take};
         rem_in   = take ? trial[scl_pkg::DIVISOR_W-1:0] : shifted[scl_pkg::DIVISOR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == scl_pkg::DIV_CNT_W'(scl_pkg::DIV_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/scl_datapath.sv]
// Datapath: slot table, counters, latency statistics, divider and result register.
module scl_datapath #(
   parameter int SAMPLE_SLOTS = 4,
   parameter int STAMP_BITS   = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [scl_pkg::INTERVAL_W-1:0]        csr_write_data,
   input  scl_pkg::req_payload_type              req_payload,
   input  scl_pkg::ctrl_cmd_type                 cmd,
   output scl_pkg::ctrl_status_type              status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output scl_pkg::rsp_payload_type              rsp_payload
);

   localparam int SLOT_IDX_W = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
   localparam int BUSY_W     = $clog2(SAMPLE_SLOTS + 1);
   localparam int TAG_WIDE_W = SLOT_IDX_W + scl_pkg::TAG_W;

   scl_pkg::req_payload_type          item_ff;
   logic [scl_pkg::INTERVAL_W-1:0]    interval_ff;
   logic [SAMPLE_SLOTS-1:0]           pending_ff, pending_in;
   logic [STAMP_BITS-1:0]             stamp_ff [SAMPLE_SLOTS];
   logic [BUSY_W-1:0]                 busy_ff, busy_in;
   logic [scl_pkg::STAT_W-1:0]        attempts_ff, attempts_in;
   logic [scl_pkg::STAT_W-1:0]        submitted_ff, submitted_in;
   logic [scl_pkg::STAT_W-1:0]        completed_ff, completed_in;
   logic [scl_pkg::STAT_W-1:0]        latest_ff, latest_in;
   logic [scl_pkg::STAT_W-1:0]        peak_ff, peak_in;
   logic [scl_pkg::STAT_W-1:0]        mean_ff, mean_in;
   logic [scl_pkg::STAT_W-1:0]        lat_ff;
   logic                              taken_ff, taken_in;
   logic [scl_pkg::TAG_W-1:0]         claimed_ff, claimed_in;
   logic                              updated_ff, updated_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   scl_pkg::rsp_payload_type          rsp_payload_ff;

   logic [TAG_WIDE_W-1:0]             tag_wide;
   logic [SLOT_IDX_W-1:0]             tag_idx;
   logic                              tag_in_range;
   logic [SLOT_IDX_W-1:0]             free_idx;
   logic                              free_any;
   logic [STAMP_BITS-1:0]             now_stamp;
   logic [STAMP_BITS-1:0]             elapsed;
   logic [scl_pkg::STAT_W-1:0]        lat_sat;
   logic                              lat_above_mean;
   logic [scl_pkg::STAT_W-1:0]        mean_gap;
   logic [scl_pkg::STAT_W-1:0]        div_dividend;
   logic [scl_pkg::DIVISOR_W-1:0]     div_divisor;
   logic                              div_done;
   logic [scl_pkg::STAT_W-1:0]        div_quotient;
   logic [scl_pkg::DIVISOR_W-1:0]     div_remainder;
   logic                              claim_now;

   assign tag_wide     = TAG_WIDE_W'(item_ff.slot_tag);
   assign tag_idx      = tag_wide[SLOT_IDX_W-1:0];
   assign tag_in_range = tag_wide < TAG_WIDE_W'(SAMPLE_SLOTS);
   assign now_stamp    = STAMP_BITS'(item_ff.timestamp);
   assign elapsed      = now_stamp - stamp_ff[tag_idx];
   assign lat_sat      = (elapsed > STAMP_BITS'(scl_pkg::STAT_MAX)) ?
                         scl_pkg::STAT_MAX : elapsed[scl_pkg::STAT_W-1:0];
   assign lat_above_mean = lat_ff >= mean_ff;
   assign mean_gap       = lat_above_mean ? (lat_ff - mean_ff) : (mean_ff - lat_ff);

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = SAMPLE_SLOTS - 1; i >= 0; i--) begin
         if (!pending_ff[i]) begin
            free_idx = SLOT_IDX_W'(i);
            free_any = 1'b1;
         end
      end
   end

   assign div_dividend = cmd.start_mod ? (attempts_ff + 32'd1) : mean_gap;
   assign div_divisor  = cmd.start_mod ? scl_pkg::DIVISOR_W'(interval_ff) :
                         ({1'b0, completed_ff} + 33'd1);

   scl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_mod | cmd.start_mean),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign claim_now = cmd.try_claim && (div_remainder == 33'd1) && free_any &&
                      item_ff.send_ok;

   always_comb begin
      pending_in   = pending_ff;
      busy_in      = busy_ff;
      attempts_in  = attempts_ff;
      submitted_in = submitted_ff;
      completed_in = completed_ff;
      latest_in    = latest_ff;
      peak_in      = peak_ff;
      mean_in      = mean_ff;
      taken_in     = taken_ff;
      claimed_in   = claimed_ff;
      updated_in   = updated_ff;

      if (cmd.capture) begin
         taken_in   = 1'b0;
         claimed_in = '0;
         updated_in = 1'b0;
      end
      if (cmd.bump_attempts) begin
         attempts_in = attempts_ff + 32'd1;
      end
      if (claim_now) begin
         pending_in[free_idx] = 1'b1;
         busy_in              = busy_ff + 1'b1;
         submitted_in         = submitted_ff + 32'd1;
         taken_in             = 1'b1;
         claimed_in           = scl_pkg::TAG_W'(free_idx);
      end
      if (cmd.commit) begin
         pending_in[tag_idx] = 1'b0;
         busy_in             = busy_ff - 1'b1;
         completed_in        = completed_ff + 32'd1;
         latest_in           = lat_ff;
         updated_in          = 1'b1;
         if (lat_ff > peak_ff) begin
            peak_in = lat_ff;
         end
         if (completed_ff == '0) begin
            mean_in = lat_ff;
         end else if (lat_above_mean) begin
            mean_in = mean_ff + div_quotient;
         end else begin
            mean_in = mean_ff - div_quotient;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= scl_pkg::INTERVAL_RESET;
         pending_ff   <= '0;
         busy_ff      <= '0;
         attempts_ff  <= '0;
         submitted_ff <= '0;
         completed_ff <= '0;
         latest_ff    <= '0;
         peak_ff      <= '0;
         mean_ff      <= '0;
         taken_ff     <= 1'b0;
         claimed_ff   <= '0;
         updated_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            interval_ff <= csr_write_data;
         end
         pending_ff   <= pending_in;
         busy_ff      <= busy_in;
         attempts_ff  <= attempts_in;
         submitted_ff <= submitted_in;
         completed_ff <= completed_in;
         latest_ff    <= latest_in;
         peak_ff      <= peak_in;
         mean_ff      <= mean_in;
         taken_ff     <= taken_in;
         claimed_ff   <= claimed_in;
         updated_ff   <= updated_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.latch_latency) begin
         lat_ff <= lat_sat;
      end
      if (claim_now) begin
         stamp_ff[free_idx] <= now_stamp;
      end
      if (cmd.load_result) begin
         rsp_payload_ff.sample_taken    <= taken_ff;
         rsp_payload_ff.claimed_slot    <= claimed_ff;
         rsp_payload_ff.latency_updated <= updated_ff;
         rsp_payload_ff.last_latency    <= latest_ff;
         rsp_payload_ff.max_latency     <= peak_ff;
         rsp_payload_ff.mean_latency    <= mean_ff;
         rsp_payload_ff.attempt_count   <= attempts_ff;
         rsp_payload_ff.submitted_count <= submitted_ff;
         rsp_payload_ff.completed_count <= completed_ff;
         rsp_payload_ff.pending_slots   <= scl_pkg::BUSY_OUT_W'(busy_ff);
      end
   end

   assign status.command          = scl_pkg::command_type'(item_ff.command);
   assign status.interval_zero    = interval_ff == '0;
   assign status.hit              = tag_in_range && pending_ff[tag_idx];
   assign status.first_completion = completed_ff == '0;
   assign status.div_done         = div_done;
   assign status.out_free         = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The busy count must always agree with the pending flags.
   assert property (@(posedge clock) disable iff (reset)
      $countones(pending_ff) == int'(busy_ff))
      else $error("busy slot count disagrees with pending flags");

   assert property (@(posedge clock) disable iff (reset)
      peak_ff >= latest_ff)
      else $error("maximum latency below last latency");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> completed_ff == $past(completed_ff) + 32'd1)
      else $error("completion not counted on commit");

   assert property (@(posedge clock) disable iff (reset)
      claim_now |=> $countones(pending_ff) == $countones($past(pending_ff)) + 1)
      else $error("claim did not mark exactly one new slot");

endmodule

[hw/rtl/scl_ctrl.sv]
// Controller state machine sequencing capture, divide, claim, commit and result.
module scl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  scl_pkg::ctrl_status_type  status,
   output scl_pkg::ctrl_cmd_type     cmd
);

   scl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         scl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = scl_pkg::ST_DISPATCH;
            end
         end
         scl_pkg::ST_DISPATCH: begin
            state_in = scl_pkg::ST_RESULT;
            unique case (status.command)
               scl_pkg::CMD_REJECT: begin
                  cmd.bump_attempts = 1'b1;
               end
               scl_pkg::CMD_SEND: begin
                  cmd.bump_attempts = 1'b1;
                  if (!status.interval_zero) begin
                     cmd.start_mod = 1'b1;
                     state_in      = scl_pkg::ST_MOD_WAIT;
                  end
               end
               scl_pkg::CMD_COMPLETE: begin
                  if (status.hit) begin
                     cmd.latch_latency = 1'b1;
                     state_in          = scl_pkg::ST_MEAN_START;
                  end
               end
               scl_pkg::CMD_UNKNOWN: begin
                  state_in = scl_pkg::ST_RESULT;
               end
               default: begin
                  state_in = scl_pkg::ST_RESULT;
               end
            endcase
         end
         scl_pkg::ST_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.try_claim = 1'b1;
               state_in      = scl_pkg::ST_RESULT;
            end
         end
         scl_pkg::ST_MEAN_START: begin
            if (status.first_completion) begin
               cmd.commit = 1'b1;
               state_in   = scl_pkg::ST_RESULT;
            end else begin
               cmd.start_mean = 1'b1;
               state_in       = scl_pkg::ST_MEAN_WAIT;
            end
         end
         scl_pkg::ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.commit = 1'b1;
               state_in   = scl_pkg::ST_RESULT;
            end
         end
         scl_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = scl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scl_pkg::ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == scl_pkg::ST_DISPATCH)
      else $error("captured transaction not dispatched");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !cmd.commit && !cmd.try_claim)
      else $error("result loaded while statistics still changing");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == scl_pkg::ST_MEAN_WAIT) && status.div_done |-> cmd.commit)
      else $error("mean divide finished without commit");

endmodule

[hw/rtl/sampled_completion_latency_monitor.sv]
// Top level of the sampled completion latency monitor.
//
//   Channel  Direction  Handshake            Contents
//   req_bus  in         valid/ready          command, send_ok, slot_tag, timestamp
//   rsp_bus  out        valid/ready          flags, latency statistics, counters
//   csr_*    in         write enable only    sample_interval
//
// A rejected attempt, unknown command or idle completion goes from dispatch straight to the result.
// A send with a non-zero interval waits for the 32-step serial divider before it claims a slot.
// The first completion commits at once; later ones wait for the divider to update the mean.
// One transaction is worked on at a time; the next is accepted while a result waits.
// Reset is synchronous and clears all statistics, slots and the interval to 8.
module sampled_completion_latency_monitor #(
   parameter int SAMPLE_SLOTS = 4,
   parameter int STAMP_BITS   = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   scl_req_if.sink                           req_bus,
   scl_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [scl_pkg::INTERVAL_W-1:0]    csr_write_data
);

   scl_pkg::ctrl_cmd_type    cmd;
   scl_pkg::ctrl_status_type status;
   logic                     req_ready;
   logic                     rsp_valid;
   scl_pkg::rsp_payload_type rsp_payload;

   scl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scl_datapath #(
      .SAMPLE_SLOTS (SAMPLE_SLOTS),
      .STAMP_BITS   (STAMP_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_bus.payload),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_payload      (rsp_payload)
   );

   assign req_bus.ready   = req_ready;
   assign rsp_bus.valid   = rsp_valid;
   assign rsp_bus.payload = rsp_payload;

endmodule
